// ===== src/kbh_pkg.sv =====
// Shared constants, register indexes and helpers for the key bigram histogram.
package kbh_pkg;

	// Field widths
	localparam int CNT_W  = 24;
	localparam int CODE_W = 7;
	localparam int KEY_W  = 8;
	localparam int RANK_W = 3;
	localparam int CFG_IDX_W = 2;

	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	// Report shape: five rank entries, then one transition entry
	localparam int NUM_TOP = 5;
	localparam logic [RANK_W-1:0] RES_LAST = RANK_W'(NUM_TOP);

	// Default number of tracked key codes
	localparam int DEF_KEY_LIMIT = 128;

	// Opcodes
	localparam logic OP_EVENT  = 1'b0;
	localparam logic OP_REPORT = 1'b1;

	// Result kinds
	localparam logic KIND_RANK  = 1'b0;
	localparam logic KIND_TRANS = 1'b1;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_EXCL_A = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_EXCL_B = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_EXCL_C = 2'd2;

	// Reset values of the excluded codes
	localparam logic [CODE_W-1:0] EXCL_A_RST = 7'd28;
	localparam logic [CODE_W-1:0] EXCL_B_RST = 7'd57;
	localparam logic [CODE_W-1:0] EXCL_C_RST = 7'd42;

	typedef logic [CNT_W-1:0] cnt_t;

	// Saturating increment of a count
	function automatic cnt_t sat_inc(input cnt_t v);
		return (v == CNT_MAX) ? v : v + cnt_t'(1);
	endfunction

endpackage

// ===== src/key_bigram_histogram_top5.sv =====
// Key bigram histogram: per-key and key-pair counters with a top-five report.
//
// Usage:
// - Command channel: an item is taken when start is high and busy is low.
//   op selects a key event (key_code, is_up) or a report request.
// - Configuration: cfg_we writes cfg_data into the excluded-code register
//   selected by cfg_idx (0..2); other indexes are dropped. Write only while idle.
// - Results: res_valid marks each result for exactly one cycle; the receiver
//   cannot stall, so results are never held back.
// - A counted key release passes through accept, key/pair memory read and write
//   back; a release that changes no count is done in the accept cycle.
// - A report scans the key memory, then the pair memory, passes the drain state,
//   and then puts out six results on consecutive cycles (five ranks, then the
//   transition, with last).
// - Both memories have one read and one write port with a registered read;
//   every access is serialized by the sequencer, so no forwarding is needed.
// - After reset, busy stays high while a clearing pass zeroes the pair memory
//   (and the key memory with it). Configuration writes are taken during that pass.
module key_bigram_histogram_top5
	import kbh_pkg::*;
#(
	parameter int KEY_LIMIT = DEF_KEY_LIMIT
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// command channel
	input  logic                 start,
	output logic                 busy,
	input  logic                 op,
	input  logic [KEY_W-1:0]     key_code,
	input  logic                 is_up,
	// configuration port
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [CODE_W-1:0]    cfg_data,
	// result channel
	output logic                 res_valid,
	output logic                 kind,
	output logic [RANK_W-1:0]    rank,
	output logic [CODE_W-1:0]    key_code_res,
	output logic [CODE_W-1:0]    prev_code,
	output logic [CNT_W-1:0]     count,
	output logic                 last
);

	localparam int KW     = (KEY_LIMIT > 1) ? $clog2(KEY_LIMIT) : 1;
	localparam int PDEPTH = KEY_LIMIT * KEY_LIMIT;
	localparam int PW     = $clog2(PDEPTH);

	localparam logic [KW-1:0] KIDX_LAST = KW'(KEY_LIMIT - 1);
	localparam logic [PW-1:0] PIDX_LAST = PW'(PDEPTH - 1);
	localparam logic [KEY_W:0] LIMIT_X  = (KEY_W+1)'(KEY_LIMIT);

	// Sequencer states
	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_EV_RD = 3'd2;
	localparam logic [2:0] ST_EV_WR = 3'd3;
	localparam logic [2:0] ST_KSCAN = 3'd4;
	localparam logic [2:0] ST_PSCAN = 3'd5;
	localparam logic [2:0] ST_DRAIN = 3'd6;
	localparam logic [2:0] ST_EMIT  = 3'd7;

	logic [2:0]        state_q;
	logic [PW-1:0]     clr_q;
	logic [CODE_W-1:0] excl_a_q, excl_b_q, excl_c_q;
	logic [KEY_W-1:0]  prev_key_q;
	logic              seen_q;

	// event transaction
	logic [KW-1:0]     ev_code_q;
	logic [PW-1:0]     ev_paddr_q;
	logic              ev_pair_q;

	// scan counters and read pipeline
	logic [KW-1:0]     kidx_q, kidx_s1;
	logic              kv_s1;
	logic [PW-1:0]     paddr_q;
	logic [KW-1:0]     x_q, y_q, x_s1, y_s1;
	logic              pv_s1;

	// ranking and best transition
	cnt_t              tc_q [NUM_TOP];
	logic [CODE_W-1:0] tk_q [NUM_TOP];
	cnt_t              tc_nx [NUM_TOP];
	logic [CODE_W-1:0] tk_nx [NUM_TOP];
	logic [NUM_TOP-1:0] gt;
	cnt_t              great_q;
	logic [CODE_W-1:0] gx_q, gy_q;
	logic [RANK_W-1:0] emit_q;

	// memories
	cnt_t              key_mem  [KEY_LIMIT];
	cnt_t              pair_mem [PDEPTH];
	cnt_t              key_rdata_q, pair_rdata_q;
	logic [KW-1:0]     key_raddr, key_waddr;
	logic [PW-1:0]     pair_raddr, pair_waddr;
	cnt_t              key_wdata, pair_wdata;
	logic              key_we, pair_we;

	// accept decode
	logic              accept;
	logic              code_in_range, prev_in_range, excluded;
	logic [KW-1:0]     code_idx, prev_idx;
	logic [PW-1:0]     ev_paddr;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	assign code_in_range = ({1'b0, key_code} < LIMIT_X);
	assign prev_in_range = ({1'b0, prev_key_q} < LIMIT_X);
	assign excluded      = (key_code == {1'b0, excl_a_q}) ||
	                       (key_code == {1'b0, excl_b_q}) ||
	                       (key_code == {1'b0, excl_c_q});
	assign code_idx = key_code[KW-1:0];
	assign prev_idx = prev_key_q[KW-1:0];
	assign ev_paddr = PW'(code_idx) * PW'(KEY_LIMIT) + PW'(prev_idx);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			excl_a_q <= EXCL_A_RST;
			excl_b_q <= EXCL_B_RST;
			excl_c_q <= EXCL_C_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_EXCL_A: excl_a_q <= cfg_data;
				REG_EXCL_B: excl_b_q <= cfg_data;
				REG_EXCL_C: excl_c_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Memory port muxing
	always_comb begin
		key_raddr  = (state_q == ST_KSCAN) ? kidx_q : ev_code_q;
		pair_raddr = (state_q == ST_PSCAN) ? paddr_q : ev_paddr_q;
		if (state_q == ST_CLEAR) begin
			key_we     = (clr_q < PW'(KEY_LIMIT));
			key_waddr  = KW'(clr_q);
			key_wdata  = '0;
			pair_we    = 1'b1;
			pair_waddr = clr_q;
			pair_wdata = '0;
		end else begin
			key_we     = (state_q == ST_EV_WR);
			key_waddr  = ev_code_q;
			key_wdata  = sat_inc(key_rdata_q);
			pair_we    = (state_q == ST_EV_WR) && ev_pair_q;
			pair_waddr = ev_paddr_q;
			pair_wdata = sat_inc(pair_rdata_q);
		end
	end

	// Key count memory
	always_ff @(posedge clk) begin
		if (key_we) begin
			key_mem[key_waddr] <= key_wdata;
		end
		key_rdata_q <= key_mem[key_raddr];
	end

	// Pair count memory
	always_ff @(posedge clk) begin
		if (pair_we) begin
			pair_mem[pair_waddr] <= pair_wdata;
		end
		pair_rdata_q <= pair_mem[pair_raddr];
	end

	// Strict-greater insertion of the key count coming off the memory
	always_comb begin
		for (int p = 0; p < NUM_TOP; p++) begin
			gt[p] = (key_rdata_q > tc_q[p]);
		end
		for (int s = 0; s < NUM_TOP; s++) begin
			tc_nx[s] = tc_q[s];
			tk_nx[s] = tk_q[s];
			if (gt[s]) begin
				if (s == 0) begin
					tc_nx[s] = key_rdata_q;
					tk_nx[s] = CODE_W'(kidx_s1);
				end else if (!gt[s-1]) begin
					tc_nx[s] = key_rdata_q;
					tk_nx[s] = CODE_W'(kidx_s1);
				end else begin
					tc_nx[s] = tc_q[s-1];
					tk_nx[s] = tk_q[s-1];
				end
			end
		end
	end

	// Ranking and best transition registers
	always_ff @(posedge clk) begin
		if (accept && op == OP_REPORT) begin
			for (int p = 0; p < NUM_TOP; p++) begin
				tc_q[p] <= '0;
				tk_q[p] <= '0;
			end
			great_q <= '0;
			gx_q    <= '0;
			gy_q    <= '0;
		end else begin
			if (kv_s1) begin
				for (int p = 0; p < NUM_TOP; p++) begin
					tc_q[p] <= tc_nx[p];
					tk_q[p] <= tk_nx[p];
				end
			end
			if (pv_s1 && pair_rdata_q > great_q) begin
				great_q <= pair_rdata_q;
				gx_q    <= CODE_W'(x_s1);
				gy_q    <= CODE_W'(y_s1);
			end
		end
	end

	// Scan pipeline stage: index travels with the memory read
	always_ff @(posedge clk) begin
		kidx_s1 <= kidx_q;
		x_s1    <= x_q;
		y_s1    <= y_q;
	end

	// Event payload
	always_ff @(posedge clk) begin
		if (accept) begin
			ev_code_q  <= code_idx;
			ev_paddr_q <= ev_paddr;
			ev_pair_q  <= seen_q && prev_in_range;
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_q      <= '0;
			prev_key_q <= '0;
			seen_q     <= 1'b0;
			kidx_q     <= '0;
			paddr_q    <= '0;
			x_q        <= '0;
			y_q        <= '0;
			kv_s1      <= 1'b0;
			pv_s1      <= 1'b0;
			emit_q     <= '0;
		end else begin
			kv_s1 <= (state_q == ST_KSCAN);
			pv_s1 <= (state_q == ST_PSCAN);
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + PW'(1);
					if (clr_q == PIDX_LAST) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						if (op == OP_REPORT) begin
							kidx_q  <= '0;
							state_q <= ST_KSCAN;
						end else if (is_up) begin
							if (!seen_q) begin
								seen_q     <= 1'b1;
								prev_key_q <= key_code;
								if (code_in_range) begin
									state_q <= ST_EV_RD;
								end
							end else if (code_in_range && !excluded) begin
								prev_key_q <= key_code;
								state_q    <= ST_EV_RD;
							end
						end
					end
				end
				ST_EV_RD: state_q <= ST_EV_WR;
				ST_EV_WR: state_q <= ST_IDLE;
				ST_KSCAN: begin
					kidx_q <= kidx_q + KW'(1);
					if (kidx_q == KIDX_LAST) begin
						paddr_q <= '0;
						x_q     <= '0;
						y_q     <= '0;
						state_q <= ST_PSCAN;
					end
				end
				ST_PSCAN: begin
					paddr_q <= paddr_q + PW'(1);
					if (y_q == KIDX_LAST) begin
						y_q <= '0;
						x_q <= x_q + KW'(1);
					end else begin
						y_q <= y_q + KW'(1);
					end
					if (paddr_q == PIDX_LAST) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					emit_q  <= '0;
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					emit_q <= emit_q + RANK_W'(1);
					if (emit_q == RES_LAST) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Result ports
	logic is_trans;
	assign is_trans     = (emit_q == RES_LAST);
	assign res_valid    = (state_q == ST_EMIT);
	assign kind         = is_trans ? KIND_TRANS : KIND_RANK;
	assign last         = is_trans;
	assign rank         = is_trans ? '0 : emit_q;
	assign key_code_res = is_trans ? gx_q : tk_q[emit_q];
	assign prev_code    = is_trans ? gy_q : '0;
	assign count        = is_trans ? great_q : tc_q[emit_q];

`ifndef SYNTHESIS
	// Results only come out of a report in progress
	a_res_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> busy)
		else $error("result strobe while idle");

	// The final result of a report closes the burst
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && last |=> !res_valid && !busy)
		else $error("result after last");

	// A report request always starts a key scan
	a_report_scan: assert property (@(posedge clk) disable iff (!arst_n)
		accept && op == OP_REPORT |=> state_q == ST_KSCAN)
		else $error("report did not start scan");

	// The ranking stays sorted by count
	a_rank_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT |-> tc_q[0] >= tc_q[1] && tc_q[1] >= tc_q[2] &&
			tc_q[2] >= tc_q[3] && tc_q[3] >= tc_q[4])
		else $error("ranking out of order");
`endif

endmodule
